/* src/pps_pkg.sv */
// shared constants, payload structs and controller/datapath signal groups
// for the preemptive priority scheduler; no dependencies
`timescale 1ns / 1ps

package pps_pkg;

    // process table size
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // field widths
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 23;
    localparam int SUM_W  = 29;
    localparam int PNUM_W = 7;

    // one process record
    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [BUR_W-1:0] burst_time;
        logic [PRI_W-1:0] priority_level;
        logic             last_process;
    } t_in_item;

    // one per-process result
    typedef struct packed {
        logic [PNUM_W-1:0] process_number;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [SUM_W-1:0]  sum_waiting;
        logic [SUM_W-1:0]  sum_turnaround;
        logic              last_result;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // store the record of the current input transfer
        logic idx_clr;    // restart the table index, drop scan results
        logic scan_step;  // evaluate the entry at the index, advance it
        logic update;     // advance time and the chosen process
        logic acc_ta;     // record completion, form turnaround
        logic acc_sum;    // form waiting time, add to totals
        logic out_cap;    // load the output register from the index entry
        logic out_next;   // advance the index to the next result
        logic clear_run;  // zero counters, time and sums
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic idx_end;    // index sits on the last loaded entry
        logic pick_found; // scan found a ready process
        logic step_done;  // the chosen process finishes in this step
        logic all_done;   // every loaded process has finished
    } t_sts;

endpackage

/* src/pps_in_if.sv */
// input channel for process records
// depends on pps_pkg
`timescale 1ns / 1ps

interface pps_in_if;
    import pps_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/pps_out_if.sv */
// output channel for per-process results
// depends on pps_pkg
`timescale 1ns / 1ps

interface pps_out_if;
    import pps_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/pps_datapath.sv */
// process table, scan registers, time, sums and output register
// depends on pps_pkg; driven by pps_controller commands
`timescale 1ns / 1ps

module pps_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pps_pkg::t_in_item   i_item,
    input  pps_pkg::t_cmd       i_cmd,
    output pps_pkg::t_sts       o_sts,
    output pps_pkg::t_out_item  o_item
);
    import pps_pkg::*;

    // process table
    logic [ARR_W-1:0]  r_arr  [MAX_PROCS];
    logic [BUR_W-1:0]  r_bur  [MAX_PROCS];
    logic [PRI_W-1:0]  r_pri  [MAX_PROCS];
    logic [BUR_W-1:0]  r_rem  [MAX_PROCS];
    logic [TIME_W-1:0] r_comp [MAX_PROCS];

    // run counters
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_fin;
    logic [TIME_W-1:0] r_time;
    logic [SUM_W-1:0]  r_wsum;
    logic [SUM_W-1:0]  r_tsum;
    logic [IDX_W-1:0]  r_idx;

    // scan results
    logic              r_found;
    logic [PRI_W-1:0]  r_best;
    logic [IDX_W-1:0]  r_pick_idx;
    logic [ARR_W-1:0]  r_pick_arr;
    logic [BUR_W-1:0]  r_pick_bur;
    logic [BUR_W-1:0]  r_pick_rem;
    logic              r_have_next;
    logic [ARR_W-1:0]  r_next;
    logic [TIME_W-1:0] r_ta;

    // output register
    t_out_item         r_out;

    // entry under the index
    logic [ARR_W-1:0]  w_arr;
    logic [BUR_W-1:0]  w_bur;
    logic [PRI_W-1:0]  w_pri;
    logic [BUR_W-1:0]  w_rem;
    logic [TIME_W-1:0] w_comp;
    logic              w_ready;
    logic              w_future;

    // time step
    logic [TIME_W-1:0] w_delta;
    logic              w_cut;
    logic [TIME_W-1:0] w_step;
    logic [TIME_W-1:0] w_wt;

    // output values
    logic [TIME_W-1:0] w_out_ta;
    logic [TIME_W-1:0] w_out_wt;

    logic [BUR_W-1:0]  w_load_bur;
    logic [IDX_W-1:0]  w_load_idx;

    assign w_arr  = r_arr[r_idx];
    assign w_bur  = r_bur[r_idx];
    assign w_pri  = r_pri[r_idx];
    assign w_rem  = r_rem[r_idx];
    assign w_comp = r_comp[r_idx];

    // readiness of the indexed entry against the current time
    assign w_ready  = (w_rem != '0) && (TIME_W'(w_arr) <= r_time);
    assign w_future = (w_rem != '0) && (TIME_W'(w_arr) > r_time);

    // run the pick until done or until the next arrival
    assign w_delta = TIME_W'(r_next) - r_time;
    assign w_cut   = r_have_next && (w_delta < TIME_W'(r_pick_rem));
    assign w_step  = w_cut ? w_delta : TIME_W'(r_pick_rem);
    assign w_wt    = r_ta - TIME_W'(r_pick_bur);

    assign w_out_ta = w_comp - TIME_W'(w_arr);
    assign w_out_wt = w_out_ta - TIME_W'(w_bur);

    // zero burst counts as one unit
    assign w_load_bur = (i_item.burst_time == '0) ? BUR_W'(1) : i_item.burst_time;
    assign w_load_idx = r_count[IDX_W-1:0];

    // status
    assign o_sts.idx_end    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.pick_found = r_found;
    assign o_sts.step_done  = !w_cut;
    assign o_sts.all_done   = (r_fin == r_count);

    assign o_item = r_out;

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(MAX_PROCS))) begin
            r_arr[w_load_idx] <= i_item.arrival_time;
            r_bur[w_load_idx] <= w_load_bur;
            r_pri[w_load_idx] <= i_item.priority_level;
            r_rem[w_load_idx] <= w_load_bur;
        end
        if (i_cmd.update && r_found) begin
            r_rem[r_pick_idx] <= r_pick_rem - w_step[BUR_W-1:0];
        end
        if (i_cmd.acc_ta) begin
            r_comp[r_pick_idx] <= r_time;
        end
    end

    // counters, time and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_run) begin
            r_count <= '0;
            r_fin   <= '0;
            r_time  <= '0;
            r_wsum  <= '0;
            r_tsum  <= '0;
        end else begin
            if (i_cmd.load && (r_count < CNT_W'(MAX_PROCS))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.update) begin
                if (r_found) begin
                    r_time <= r_time + w_step;
                end else begin
                    r_time <= TIME_W'(r_next);
                end
            end
            if (i_cmd.acc_ta) begin
                r_fin <= r_fin + CNT_W'(1);
            end
            if (i_cmd.acc_sum) begin
                r_wsum <= r_wsum + SUM_W'(w_wt);
                r_tsum <= r_tsum + SUM_W'(r_ta);
            end
        end
    end

    // table index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step || i_cmd.out_next) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // scan: best ready entry and earliest pending arrival
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) begin
            r_found     <= 1'b0;
            r_have_next <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (w_ready && (!r_found || (w_pri < r_best))) begin
                r_found    <= 1'b1;
                r_best     <= w_pri;
                r_pick_idx <= r_idx;
                r_pick_arr <= w_arr;
                r_pick_bur <= w_bur;
                r_pick_rem <= w_rem;
            end
            if (w_future && (!r_have_next || (w_arr < r_next))) begin
                r_have_next <= 1'b1;
                r_next      <= w_arr;
            end
        end
    end

    // turnaround of the finished process
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_ta) begin
            r_ta <= r_time - TIME_W'(r_pick_arr);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_cap) begin
            r_out.process_number  <= PNUM_W'(r_idx) + PNUM_W'(1);
            r_out.completion_time <= w_comp;
            r_out.turnaround_time <= w_out_ta;
            r_out.waiting_time    <= w_out_wt;
            r_out.sum_waiting     <= r_wsum;
            r_out.sum_turnaround  <= r_tsum;
            r_out.last_result     <= o_sts.idx_end;
        end
    end

endmodule

/* src/pps_controller.sv */
// sequencer for load, scan, time step, accumulate and result phases
// depends on pps_pkg; commands pps_datapath
`timescale 1ns / 1ps

module pps_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pps_pkg::t_sts  i_sts,
    output pps_pkg::t_cmd  o_cmd
);
    import pps_pkg::*;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_ACC1   = 3'd3;
    localparam logic [2:0] S_ACC2   = 3'd4;
    localparam logic [2:0] S_OUTC   = 3'd5;
    localparam logic [2:0] S_OUTW   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // no record is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUTW);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_end) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update  = 1'b1;
                o_cmd.idx_clr = 1'b1;
                if (i_sts.pick_found && i_sts.step_done) begin
                    n_state = S_ACC1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ACC1: begin
                o_cmd.acc_ta = 1'b1;
                n_state      = S_ACC2;
            end
            S_ACC2: begin
                o_cmd.acc_sum = 1'b1;
                if (i_sts.all_done) begin
                    n_state = S_OUTC;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_OUTC: begin
                o_cmd.out_cap = 1'b1;
                n_state       = S_OUTW;
            end
            S_OUTW: begin
                if (i_out_ready) begin
                    if (i_sts.idx_end) begin
                        o_cmd.clear_run = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_OUTC;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

/* src/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler: takes process records (arrival, burst,
// priority) one per cycle into a table of pps_pkg::MAX_PROCS entries; the
// record marked last_process starts a run from time zero that serves, at each
// time unit, the arrived unfinished process with the smallest priority
// number (ties to the earliest loaded), then delivers one result per
// process in load order with the run totals, and clears for the next batch.
// Records beyond the table size are dropped; a zero burst counts as one.
// The run moves from event to event (a completion or an arrival, at most
// 2n events for n records); each event costs one scan of the table, one
// entry per cycle, plus an update step, and a completion adds the two
// accumulate steps, so the run time is set by the table scan. Each result
// is captured, then offered and held until the output takes it. No record
// is taken during a run.
// depends on pps_pkg, pps_in_if, pps_out_if, pps_controller, pps_datapath
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pps_in_if.sink   i_in,
    pps_out_if.source o_out
);
    import pps_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_out_item w_out_item;
    logic      w_in_ready;
    logic      w_out_valid;

    // sequencer
    pps_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.data.last_process),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // table and arithmetic
    pps_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_item  (w_out_item)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

endmodule

/* src/pps_checker.sv */
// port-level checks over time for the preemptive priority scheduler
// depends on pps_pkg; bound to preemptive_priority_scheduler
`timescale 1ns / 1ps

module pps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_last,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pps_pkg::t_out_item  i_out_data
);
    import pps_pkg::*;

    // no record is taken while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is offered");

    // a last record starts a run, so loading stops
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("loading continued after the last record");

    // after the final result transfer the block loads again
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_data.last_result) |=> i_in_ready)
        else $error("not ready for records after the final result");

    // results come in load order
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_data.last_result) |=> ##1
        (i_out_valid && (i_out_data.process_number ==
            $past(i_out_data.process_number, 2) + PNUM_W'(1))))
        else $error("result out of load order");

    // an offered result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.data.last_process),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* tb/sv/preemptive_priority_scheduler_test.sv */
// self-checking testbench for the preemptive priority scheduler: random and
// directed process batches, a local scheduling predictor, per-field result checks
// depends on pps_pkg, pps_in_if, pps_out_if and preemptive_priority_scheduler
`timescale 1ns / 1ps

module preemptive_priority_scheduler_test;
    import pps_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 200;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 40;
    localparam int RAND_RECORDS = 76;

    // one record waiting to be offered, with its pre-drawn gap
    typedef struct {
        t_in_item    rec;
        int unsigned gap;
        bit          wait_drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    pps_in_if  in_ch ();
    pps_out_if out_ch ();

    preemptive_priority_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_pending    pending_records[$];
    t_out_item   expected_results[$];

    // predictor copy of the process table
    int unsigned arr_tab   [MAX_PROCS];
    int unsigned burst_tab [MAX_PROCS];
    int unsigned prio_tab  [MAX_PROCS];
    int unsigned tab_count;

    int unsigned records_taken;
    int unsigned records_dropped;
    int unsigned batches_run;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          long_hold_done;

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // run the batch in the table from time zero, event to event, and queue its results
    function automatic void schedule_batch();
        int unsigned left [MAX_PROCS];
        int unsigned done_at [MAX_PROCS];
        int unsigned now, finished, step, best, next_arr, ta, wt, sum_wt, sum_ta;
        int          pick;
        bit          have;
        t_out_item   res;
        now      = 0;
        finished = 0;
        sum_wt   = 0;
        sum_ta   = 0;
        for (int i = 0; i < tab_count; i++) begin
            left[i]    = burst_tab[i];
            done_at[i] = 0;
        end
        while (finished < tab_count) begin
            pick = -1;
            best = 0;
            for (int i = 0; i < tab_count; i++) begin
                if (arr_tab[i] <= now && left[i] > 0 && (pick < 0 || prio_tab[i] < best)) begin
                    best = prio_tab[i];
                    pick = i;
                end
            end
            // nothing ready: skip ahead to the earliest pending arrival
            if (pick < 0) begin
                have     = 1'b0;
                next_arr = 0;
                for (int i = 0; i < tab_count; i++) begin
                    if (left[i] > 0 && (!have || arr_tab[i] < next_arr)) begin
                        next_arr = arr_tab[i];
                        have     = 1'b1;
                    end
                end
                now = next_arr;
                continue;
            end
            // serve until completion or the next arrival
            step = left[pick];
            for (int i = 0; i < tab_count; i++) begin
                if (left[i] > 0 && arr_tab[i] > now && arr_tab[i] - now < step) begin
                    step = arr_tab[i] - now;
                end
            end
            left[pick] -= step;
            now        += step;
            if (left[pick] == 0) begin
                done_at[pick] = now;
                ta            = now - arr_tab[pick];
                wt            = ta - burst_tab[pick];
                sum_wt       += wt;
                sum_ta       += ta;
                finished++;
            end
        end
        for (int i = 0; i < tab_count; i++) begin
            res.process_number  = PNUM_W'(i + 1);
            res.completion_time = TIME_W'(done_at[i]);
            res.turnaround_time = TIME_W'(done_at[i] - arr_tab[i]);
            res.waiting_time    = TIME_W'(done_at[i] - arr_tab[i] - burst_tab[i]);
            res.sum_waiting     = SUM_W'(sum_wt);
            res.sum_turnaround  = SUM_W'(sum_ta);
            res.last_result     = (i + 1 == tab_count);
            expected_results.push_back(res);
        end
        tab_count = 0;
        batches_run++;
    endfunction

    // predictor update for one accepted record
    function automatic void take_record(t_in_item rec);
        records_taken++;
        if (tab_count < MAX_PROCS) begin
            arr_tab[tab_count]   = 32'(rec.arrival_time);
            burst_tab[tab_count] = (rec.burst_time == '0) ? 32'd1 : 32'(rec.burst_time);
            prio_tab[tab_count]  = 32'(rec.priority_level);
            tab_count++;
        end else begin
            records_dropped++;
        end
        if (rec.last_process) begin
            schedule_batch();
        end
    endfunction

    function automatic void report_field(string name, longint unsigned exp_v,
                                         logic [31:0] act_v);
        if (act_v !== exp_v[31:0]) begin
            $display("%0t: result mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // compare one result transfer with the oldest expectation
    function automatic void check_result(t_out_item got);
        t_out_item exp_r;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual process %0d",
                     $time, got.process_number);
            mismatches++;
            return;
        end
        exp_r = expected_results.pop_front();
        report_field("process_number", 64'(exp_r.process_number),
                     32'(got.process_number));
        report_field("completion_time", 64'(exp_r.completion_time),
                     32'(got.completion_time));
        report_field("turnaround_time", 64'(exp_r.turnaround_time),
                     32'(got.turnaround_time));
        report_field("waiting_time", 64'(exp_r.waiting_time),
                     32'(got.waiting_time));
        report_field("sum_waiting", 64'(exp_r.sum_waiting),
                     32'(got.sum_waiting));
        report_field("sum_turnaround", 64'(exp_r.sum_turnaround),
                     32'(got.sum_turnaround));
        report_field("last_result", 64'(exp_r.last_result),
                     32'(got.last_result));
    endfunction

    // record driver: at most one nonblocking write of valid per edge
    int unsigned gap_left;
    bit          gap_loaded;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left     = 0;
            gap_loaded   = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                take_record(in_ch.data);
            end
            // channel is free unless a record is still waiting to be taken
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (pending_records.size() != 0 && !gap_loaded) begin
                    gap_left   = pending_records[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pending_records.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (pending_records[0].wait_drain && expected_results.size() != 0) begin
                    in_ch.valid <= 1'b0;
                end else if (gap_left != 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.data  <= pending_records.pop_front().rec;
                    in_ch.valid <= 1'b1;
                    gap_loaded   = 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure and one long hold-off
    int unsigned stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result(out_ch.data);
                results_seen++;
                // quiet stretches every third block of twenty results
                stall_left = ((results_seen / 20) % 3 == 1) ? 0 : $urandom_range(0, 19);
                if (results_seen >= HOLD_AT && !long_hold_done) begin
                    stall_left     = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end else if (stall_left != 0) begin
                stall_left--;
            end
            out_ch.ready <= (stall_left == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("preemptive_priority_scheduler verification failed");
            $finish;
        end
    end

    function automatic void add_record(int unsigned arr, int unsigned bur, int unsigned pri,
                                       bit last, bit quiet, bit drain);
        t_pending p;
        p.rec.arrival_time   = ARR_W'(arr);
        p.rec.burst_time     = BUR_W'(bur);
        p.rec.priority_level = PRI_W'(pri);
        p.rec.last_process   = last;
        p.gap                = quiet ? 0 : $urandom_range(0, 19);
        p.wait_drain         = drain;
        pending_records.push_back(p);
    endfunction

    initial begin
        int unsigned queued, size, arr, bur, pri;
        bit          quiet, drain, wide;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        tab_count      = 0;
        records_taken  = 0;
        records_dropped = 0;
        batches_run    = 0;
        results_seen   = 0;
        mismatches     = 0;
        cycle_count    = 0;
        long_hold_done = 1'b0;

        // directed: field extremes as single-process batches
        add_record(0, 1, 0, 1'b1, 1'b0, 1'b0);
        add_record(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0);
        // preemption, equal-priority tie and an idle stretch before the last arrival
        add_record(2, 5, 3, 1'b0, 1'b0, 1'b0);
        add_record(3, 2, 1, 1'b0, 1'b1, 1'b0);
        add_record(4, 2, 1, 1'b0, 1'b0, 1'b0);
        add_record(30, 1, 0, 1'b1, 1'b0, 1'b0);
        // full table, then one dropped record and a dropped record that starts the run
        for (int i = 0; i < MAX_PROCS; i++) begin
            add_record((i % 2) ? 16'hAAAA : 16'h5555 + i, (i % 2) ? 16'h5555 : 16'h2AAA - i,
                       (i % 3) ? 8'hAA : 8'h55, 1'b0, (i < 8), 1'b0);
        end
        add_record(16'h0001, 16'h0002, 8'h00, 1'b0, 1'b0, 1'b0);
        add_record(16'h0003, 16'h0004, 8'h01, 1'b1, 1'b0, 1'b0);

        // random batches: mostly contended small values, some full-range fields
        queued = 0;
        while (queued < RAND_RECORDS) begin
            size  = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3)
                                                : $urandom_range(1, MAX_PROCS);
            quiet = ($urandom_range(0, 3) == 0);
            wide  = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < size; i++) begin
                arr  = wide ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 40);
                bur  = wide ? $urandom_range(1, 16'hFFFF) : $urandom_range(1, 20);
                pri  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 7);
                // the sender waits for a drained block at the start and midway
                drain = (queued == 0) || (queued == RAND_RECORDS / 2);
                add_record(arr, bur, pri, (i + 1 == size), quiet, drain);
                queued++;
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all records taken, all results in, then a settling stretch
        while (pending_records.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d records (%0d dropped on a full table) in %0d batches",
                 records_taken, records_dropped, batches_run);
        $display("checked %0d results, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("preemptive_priority_scheduler verification clean");
        end else begin
            $display("preemptive_priority_scheduler verification failed");
        end
        $finish;
    end

endmodule

/* preemptive_priority_scheduler.f */
src/pps_pkg.sv
src/pps_in_if.sv
src/pps_out_if.sv
src/pps_datapath.sv
src/pps_controller.sv
src/preemptive_priority_scheduler.sv
src/pps_checker.sv
tb/sv/preemptive_priority_scheduler_test.sv
